@@ rtl/wfc_pkg.sv @@
// shared types and constants for the word frequency counter
package wfc_pkg;

  localparam int Entries   = 128;
  localparam int MaxWord   = 30;
  localparam int CountBits = 24;
  localparam int SlotW     = 7;
  localparam int LenW      = 5;
  localparam int UsedW     = 8;
  localparam int CharW     = 8;

  localparam logic [1:0] FUNC_TEXT = 2'd0;
  localparam logic [1:0] FUNC_END  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [LenW-1:0] WORD_LIMIT = LenW'(MaxWord - 1);
  localparam logic [CountBits-1:0] COUNT_MAX = '1;

  typedef logic [CharW-1:0] char_t;
  typedef char_t [MaxWord-2:0] word_t;

  // entry handed along the cell chain
  typedef struct packed {
    logic              used;
    logic [LenW-1:0]   len;
    word_t             chars;
    logic [CountBits-1:0] cnt;
  } entry_t;

  // search token moving down the chain
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [SlotW-1:0] slot;
    logic [CountBits-1:0] cnt;
  } token_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  // fold to lower case
  function automatic char_t fold_char(input char_t c);
    if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic logic is_word_char(input char_t c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) || c == 8'h27;
  endfunction

endpackage

@@ rtl/wfc_if.sv @@
// valid/ready channel interfaces
interface wfc_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;
  logic [6:0] entry_index;
  logic [4:0] char_pos;
  modport source (output valid, func, char_code, entry_index, char_pos, input ready);
  modport sink (input valid, func, char_code, entry_index, char_pos, output ready);
endinterface

interface wfc_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        word_done;
  logic [6:0]  slot;
  logic [23:0] count;
  logic        is_new;
  logic [4:0]  word_length;
  logic        table_full;
  logic [7:0]  distinct_count;
  logic [31:0] total_words;
  logic [7:0]  read_char;
  modport source (output valid, word_done, slot, count, is_new, word_length, table_full,
                  distinct_count, total_words, read_char, input ready);
  modport sink (input valid, word_done, slot, count, is_new, word_length, table_full,
                distinct_count, total_words, read_char, output ready);
endinterface

@@ rtl/word_frequency_counter.sv @@
// top level: word assembly, slot cell chain and result register
// A text byte that does not end a word is taken while the block stays idle.
// A finished word is latched as the search key, and in the next cycle a token
// enters the chain of 128 slot cells and moves one cell per cycle, so an item
// that logs a word holds off the next item until its result has been taken;
// reads and end-of-text items without a word also wait for their result to be
// taken. No clearing pass is needed after reset.
module word_frequency_counter import wfc_pkg::*; (
  input logic clk,
  input logic rst,
  wfc_in_if.sink   in_ch,
  wfc_out_if.source out_ch
);
  state_t state, state_next;
  word_t buffer;
  logic [LenW-1:0] word_len, key_len;
  word_t key;
  logic [UsedW-1:0] used_slots;
  logic [31:0] word_total;
  token_t tok [Entries+1];
  entry_t ent [Entries];
  logic place;
  logic [SlotW-1:0] place_slot;
  logic accept, need_log, pending;
  logic launch;
  char_t c;

  assign in_ch.ready = (state == ST_IDLE) && !out_ch.valid;
  assign accept = in_ch.valid && in_ch.ready;
  assign c = fold_char(in_ch.char_code);
  assign pending = word_len != '0;
  always_comb begin
    need_log = 1'b0;
    if (in_ch.func == FUNC_TEXT) begin
      need_log = is_word_char(c) ? (word_len >= WORD_LIMIT) : pending;
    end else if (in_ch.func == FUNC_END) begin
      need_log = pending;
    end
  end

  // token starts in the cycle after the key is latched
  always_comb begin
    tok[0].active = launch;
    tok[0].hit = 1'b0;
    tok[0].slot = '0;
    tok[0].cnt = '0;
  end

  for (genvar g = 0; g < Entries; g++) begin : g_cell
    wfc_cell u_cell (
      .clk, .rst, .idx(SlotW'(g)), .tok_in(tok[g]), .key_len, .key,
      .place, .place_slot, .tok_out(tok[g+1]), .entry(ent[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && need_log) state_next = ST_SEARCH;
      ST_SEARCH: if (tok[Entries].active) state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign place = (state == ST_SEARCH) && tok[Entries].active && !tok[Entries].hit &&
                 used_slots < UsedW'(Entries);
  assign place_slot = used_slots[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      word_len <= '0;
      used_slots <= '0;
      word_total <= '0;
      launch <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      launch <= accept && need_log;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (accept) begin
        if (need_log) begin
          key_len <= word_len;
          for (int i = 0; i < MaxWord - 1; i++) begin
            key[i] <= (LenW'(i) < word_len) ? buffer[i] : '0;
          end
          word_len <= '0;
        end else if (in_ch.func == FUNC_TEXT) begin
          if (is_word_char(c)) begin
            buffer[word_len[LenW-1:0]] <= c;
            word_len <= word_len + 1'b1;
          end else begin
            word_len <= '0;
          end
        end
        if (!need_log && (in_ch.func == FUNC_END || in_ch.func == FUNC_READ)) begin
          out_ch.valid <= 1'b1;
          out_ch.word_done <= 1'b0;
          out_ch.is_new <= 1'b0;
          out_ch.table_full <= 1'b0;
          out_ch.distinct_count <= used_slots;
          out_ch.total_words <= word_total;
          if (in_ch.func == FUNC_READ) begin
            out_ch.slot <= in_ch.entry_index;
            if (UsedW'(in_ch.entry_index) < used_slots) begin
              out_ch.count <= ent[in_ch.entry_index].cnt;
              out_ch.word_length <= ent[in_ch.entry_index].len;
              if (in_ch.char_pos < ent[in_ch.entry_index].len) begin
                out_ch.read_char <= ent[in_ch.entry_index].chars[in_ch.char_pos];
              end else begin
                out_ch.read_char <= '0;
              end
            end else begin
              out_ch.count <= '0;
              out_ch.word_length <= '0;
              out_ch.read_char <= '0;
            end
          end else begin
            out_ch.slot <= '0;
            out_ch.count <= '0;
            out_ch.word_length <= '0;
            out_ch.read_char <= '0;
          end
        end
      end
      if (state == ST_SEARCH && tok[Entries].active) begin
        out_ch.valid <= 1'b1;
        out_ch.word_done <= 1'b1;
        out_ch.word_length <= key_len;
        out_ch.read_char <= '0;
        if (tok[Entries].hit) begin
          out_ch.is_new <= 1'b0;
          out_ch.table_full <= 1'b0;
          out_ch.slot <= tok[Entries].slot;
          out_ch.count <= tok[Entries].cnt;
          out_ch.distinct_count <= used_slots;
          out_ch.total_words <= (word_total == '1) ? word_total : word_total + 1'b1;
          if (word_total != '1) word_total <= word_total + 1'b1;
        end else if (place) begin
          out_ch.is_new <= 1'b1;
          out_ch.table_full <= 1'b0;
          out_ch.slot <= place_slot;
          out_ch.count <= CountBits'(1);
          out_ch.distinct_count <= used_slots + 1'b1;
          used_slots <= used_slots + 1'b1;
          out_ch.total_words <= (word_total == '1) ? word_total : word_total + 1'b1;
          if (word_total != '1) word_total <= word_total + 1'b1;
        end else begin
          out_ch.is_new <= 1'b0;
          out_ch.table_full <= 1'b1;
          out_ch.slot <= '0;
          out_ch.count <= '0;
          out_ch.distinct_count <= used_slots;
          out_ch.total_words <= word_total;
        end
      end
    end
  end
endmodule

@@ rtl/wfc_cell.sv @@
// one table slot: compares the passing word and updates its own count
module wfc_cell import wfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [SlotW-1:0] idx,
  input  token_t           tok_in,
  input  logic [LenW-1:0]  key_len,
  input  word_t            key,
  input  logic             place,
  input  logic [SlotW-1:0] place_slot,
  output token_t           tok_out,
  output entry_t           entry
);
  logic match;
  word_t masked;

  always_comb begin
    for (int i = 0; i < MaxWord - 1; i++) begin
      masked[i] = (LenW'(i) < key_len) ? entry.chars[i] : '0;
    end
  end

  assign match = tok_in.active && !tok_in.hit && entry.used &&
                 entry.len == key_len && masked == key;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
      entry.used <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
      if (place && place_slot == idx) begin
        entry.used <= 1'b1;
      end
    end
    tok_out.hit  <= tok_in.hit | match;
    tok_out.slot <= match ? idx : tok_in.slot;
    if (match) begin
      tok_out.cnt <= (entry.cnt == COUNT_MAX) ? entry.cnt : entry.cnt + 1'b1;
      if (entry.cnt != COUNT_MAX) entry.cnt <= entry.cnt + 1'b1;
    end else begin
      tok_out.cnt <= tok_in.cnt;
    end
    if (place && place_slot == idx) begin
      entry.len   <= key_len;
      entry.chars <= key;
      entry.cnt   <= CountBits'(1);
    end
  end
endmodule

@@ rtl/wfc_checker.sv @@
// port-level assertions for the word frequency counter
module wfc_checker import wfc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        in_ready,
  input logic        word_done,
  input logic        table_full,
  input logic        is_new,
  input logic [7:0]  distinct_count,
  input logic [7:0]  read_char,
  input logic [23:0] count
);
  a_full_no_new: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> word_done && !is_new && count == '0) else $error("full");
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new |-> count == 24'd1 && word_done) else $error("new");
  a_distinct_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distinct_count <= 8'd128) else $error("distinct");
  a_char_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_done |-> read_char == '0) else $error("char");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && !in_ready) else $error("hold");
endmodule

bind word_frequency_counter wfc_checker u_wfc_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .in_ready(in_ch.ready), .word_done(out_ch.word_done), .table_full(out_ch.table_full),
  .is_new(out_ch.is_new), .distinct_count(out_ch.distinct_count),
  .read_char(out_ch.read_char), .count(out_ch.count)
);
